/* design/lpht_pkg.sv */
// Shared types and constants for the linear probe hash table unit.
// No dependencies; imported by every module of the block.
package lpht_pkg;

  // fixed field widths of the item and result ports
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned HOME_W  = 8;
  localparam int unsigned CAP_W   = 9;
  localparam int unsigned SLOT_W  = 8;

  // capacity register value after reset
  localparam int unsigned CAP_RESET = 256;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // write strobes from the controller to the slot store
  typedef struct packed {
    logic key_we;
    logic val_we;
  } lpht_wr_t;

endpackage

/* design/linear_probe_hash_table_unit.sv */
// Top level of the linear probe hash table: probe controller, capacity
// register and result register. Depends on lpht_pkg, lpht_mod, lpht_store.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item: command, key,
//   value and home slot. Output channel (out_valid_o / out_stall_i) returns
//   exactly one result item per input item: status, found value, slot and
//   entry count. Items are taken one at a time; in_stall_o is high while
//   an item is in work.
//   Flow: after acceptance the home slot is reduced modulo the capacity
//   (8 remainder steps, then a hand-over), then up to C slots are probed
//   (C = effective capacity, one slot read per cycle), then the result is
//   written back and loaded. A key hit ends the probe early.
//   The result sits in an output register; the next item is accepted while
//   it waits. If the receiver stalls and a second result is ready, the
//   controller holds in its write-back state until the register frees up.
//   Reset: a clearing pass drops every valid mark, one of SLOTS entries per
//   cycle; no item is accepted before it ends. Capacity (cfg_we_i) resets to
//   256; the user must write it between items, with nothing in work; the block does not enforce it.
module linear_probe_hash_table_unit
  import lpht_pkg::*;
#(
  parameter int unsigned SLOTS      = 256,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CAP_W-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic [KEY_W-1:0]   key_i,
  input  logic [VALUE_W-1:0] value_i,
  input  logic [HOME_W-1:0]  home_slot_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               status_o,
  output logic [VALUE_W-1:0] found_value_o,
  output logic [SLOT_W-1:0]  slot_o,
  output logic [CAP_W-1:0]   entry_count_o
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned CW = ((AW + 1) > CAP_W) ? (AW + 1) : CAP_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_FIN
  } state_e;

  // state and registers
  state_e                state_q, state_d;
  logic [CAP_W-1:0]      cap_q;
  logic [AW-1:0]         clr_q, clr_d;
  logic [CAP_W-1:0]      count_q, count_d;
  logic                  cmd_q, cmd_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [AW-1:0]         s_q, s_d;
  logic [CW-1:0]         iss_q, iss_d;
  logic                  rvld_q, rvld_d;
  logic [AW-1:0]         rslot_q, rslot_d;
  logic                  rlast_q, rlast_d;
  logic                  hit_q, hit_d;
  logic [AW-1:0]         hit_slot_q, hit_slot_d;
  logic                  emp_q, emp_d;
  logic [AW-1:0]         emp_slot_q, emp_slot_d;
  logic [VALUE_BITS-1:0] fval_q, fval_d;
  logic                  out_valid_q, out_valid_d;
  logic                  status_q, status_d;
  logic [VALUE_W-1:0]    found_q, found_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;

  // combinational helpers
  logic [CW-1:0]         ecap;
  logic [63:0]           key_ext;
  logic [63:0]           val_ext;
  logic [63:0]           fval_ext;
  logic [CW-1:0]         rem_ext;
  logic [CW-1:0]         slot_ext;
  logic [AW-1:0]         res_slot;
  logic                  out_free;
  logic                  accept;
  logic                  probe_hit;

  // remainder unit and store connections
  logic                  mod_start;
  logic                  mod_done;
  logic [CAP_W-1:0]      mod_rem;
  lpht_wr_t              wr;
  logic [AW-1:0]         wr_addr;
  logic                  wr_vld;
  logic                  rd_vld;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;

  // effective capacity: zero acts as one, saturated at SLOTS
  always_comb begin
    if (cap_q == '0) begin
      ecap = CW'(1);
    end else if (CW'(cap_q) > CW'(SLOTS)) begin
      ecap = CW'(SLOTS);
    end else begin
      ecap = CW'(cap_q);
    end
  end

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_W'(CAP_RESET);
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  assign key_ext   = 64'(key_i);
  assign val_ext   = 64'(value_i);
  assign fval_ext  = 64'(fval_q);
  assign rem_ext   = CW'(mod_rem);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign accept    = (state_q == ST_IDLE) && in_valid_i;
  assign mod_start = accept;
  assign probe_hit = rvld_q && rd_vld && (rd_key == key_q);

  lpht_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (home_slot_i),
    .divisor_i  (ecap[CAP_W-1:0]),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  lpht_store #(
    .SLOTS      (SLOTS),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS),
    .AW         (AW)
  ) u_store (
    .clk_i     (clk_i),
    .rd_addr_i (s_q),
    .rd_vld_o  (rd_vld),
    .rd_key_o  (rd_key),
    .rd_val_o  (rd_val),
    .wr_i      (wr),
    .wr_addr_i (wr_addr),
    .wr_vld_i  (wr_vld),
    .wr_key_i  (key_q),
    .wr_val_i  (val_q)
  );

  // slot of a successful item, hit takes priority over empty slot
  assign res_slot = hit_q ? hit_slot_q : emp_slot_q;
  assign slot_ext = CW'(res_slot);

  // controller next state
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    count_d     = count_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    val_d       = val_q;
    s_d         = s_q;
    iss_d       = iss_q;
    rvld_d      = 1'b0;
    rslot_d     = s_q;
    rlast_d     = (iss_q == ecap - CW'(1));
    hit_d       = hit_q;
    hit_slot_d  = hit_slot_q;
    emp_d       = emp_q;
    emp_slot_d  = emp_slot_q;
    fval_d      = fval_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    found_d     = found_q;
    slot_d      = slot_q;
    wr          = '0;
    wr_addr     = clr_q;
    wr_vld      = 1'b0;

    case (state_q)
      // drop every valid mark after reset
      ST_CLEAR: begin
        wr.key_we = 1'b1;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end

      // take the item
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = command_i;
          key_d   = key_ext[KEY_BITS-1:0];
          val_d   = val_ext[VALUE_BITS-1:0];
          state_d = ST_MOD;
        end
      end

      // wait for home slot modulo capacity
      ST_MOD: begin
        if (mod_done) begin
          s_d     = rem_ext[AW-1:0];
          iss_d   = '0;
          hit_d   = 1'b0;
          emp_d   = 1'b0;
          state_d = ST_SCAN;
        end
      end

      // one slot read per cycle, check the previous read
      ST_SCAN: begin
        if (iss_q != ecap) begin
          rvld_d = 1'b1;
          iss_d  = iss_q + CW'(1);
          if (CW'(s_q) + CW'(1) == ecap) begin
            s_d = '0;
          end else begin
            s_d = s_q + AW'(1);
          end
        end
        if (rvld_q) begin
          if (probe_hit) begin
            hit_d      = 1'b1;
            hit_slot_d = rslot_q;
            fval_d     = rd_val;
            state_d    = ST_FIN;
          end else begin
            if (!rd_vld && !emp_q) begin
              emp_d      = 1'b1;
              emp_slot_d = rslot_q;
            end
            if (rlast_q) begin
              state_d = ST_FIN;
            end
          end
        end
      end

      // write back and load the result register
      ST_FIN: begin
        wr_addr = res_slot;
        wr_vld  = 1'b1;
        if (out_free) begin
          out_valid_d = 1'b1;
          found_d     = '0;
          if (hit_q) begin
            status_d = STATUS_OK;
            slot_d   = slot_ext[SLOT_W-1:0];
            if (cmd_q == CMD_LOOKUP) begin
              found_d = fval_ext[VALUE_W-1:0];
            end else begin
              wr.val_we = 1'b1;
            end
          end else if ((cmd_q == CMD_INSERT) && emp_q) begin
            status_d  = STATUS_OK;
            slot_d    = slot_ext[SLOT_W-1:0];
            wr.key_we = 1'b1;
            wr.val_we = 1'b1;
            count_d   = count_q + CAP_W'(1);
          end else begin
            status_d = STATUS_FAIL;
            slot_d   = '0;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      rvld_q      <= rvld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    val_q      <= val_d;
    s_q        <= s_d;
    iss_q      <= iss_d;
    rslot_q    <= rslot_d;
    rlast_q    <= rlast_d;
    hit_q      <= hit_d;
    hit_slot_q <= hit_slot_d;
    emp_q      <= emp_d;
    emp_slot_q <= emp_slot_d;
    fval_q     <= fval_d;
    status_q   <= status_d;
    found_q    <= found_d;
    slot_q     <= slot_d;
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_value_o = found_q;
  assign slot_o        = slot_q;
  assign entry_count_o = count_q;

  // accepted item keeps the input stalled until its result is produced
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o
  ) else $error("input not stalled after accepting an item");

  // a new result appears only out of the write-back state
  a_result_from_fin: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN)
  ) else $error("result loaded outside write-back");

  // entry count grows by one at a time
  a_count_step: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == CAP_W'($past(count_q) + CAP_W'(1)))
  ) else $error("entry count changed by more than one");

endmodule

/* design/lpht_mod.sv */
// Restoring remainder unit: home slot modulo the effective capacity,
// one dividend bit per cycle. Depends on lpht_pkg.
module lpht_mod
  import lpht_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [HOME_W-1:0] dividend_i,
  input  logic [CAP_W-1:0]  divisor_i,
  output logic             done_o,
  output logic [CAP_W-1:0]  rem_o
);

  localparam int unsigned CNT_W = (HOME_W > 1) ? $clog2(HOME_W) : 1;

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [HOME_W-1:0] sh_q;
  logic [CAP_W-1:0]  div_q;
  logic [CAP_W-1:0]  rem_q;
  logic [CAP_W:0]    trial;
  logic [CAP_W:0]    diff;
  logic [CAP_W-1:0]  rem_next;

  // shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {rem_q, sh_q[HOME_W-1]};
    diff  = trial - {1'b0, div_q};
    if (trial >= {1'b0, div_q}) begin
      rem_next = diff[CAP_W-1:0];
    end else begin
      rem_next = trial[CAP_W-1:0];
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CNT_W'(HOME_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(HOME_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      sh_q  <= {sh_q[HOME_W-2:0], 1'b0};
      rem_q <= rem_next;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* design/lpht_store.sv */
// Slot store: key memory with valid mark and value memory, one write and
// one registered read per cycle each. Depends on lpht_pkg.
module lpht_store
  import lpht_pkg::*;
#(
  parameter int unsigned SLOTS      = 256,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned AW         = 8
) (
  input  logic                  clk_i,
  input  logic [AW-1:0]         rd_addr_i,
  output logic                  rd_vld_o,
  output logic [KEY_BITS-1:0]   rd_key_o,
  output logic [VALUE_BITS-1:0] rd_val_o,
  input  lpht_wr_t              wr_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  logic                  wr_vld_i,
  input  logic [KEY_BITS-1:0]   wr_key_i,
  input  logic [VALUE_BITS-1:0] wr_val_i
);

  logic [KEY_BITS:0]     key_mem [SLOTS];
  logic [VALUE_BITS-1:0] val_mem [SLOTS];
  logic [KEY_BITS:0]     key_rd_q;
  logic [VALUE_BITS-1:0] val_rd_q;

  // key memory, valid mark in the top bit
  always_ff @(posedge clk_i) begin
    if (wr_i.key_we) begin
      key_mem[wr_addr_i] <= {wr_vld_i, wr_key_i};
    end
    key_rd_q <= key_mem[rd_addr_i];
  end

  // value memory
  always_ff @(posedge clk_i) begin
    if (wr_i.val_we) begin
      val_mem[wr_addr_i] <= wr_val_i;
    end
    val_rd_q <= val_mem[rd_addr_i];
  end

  assign rd_vld_o = key_rd_q[KEY_BITS];
  assign rd_key_o = key_rd_q[KEY_BITS-1:0];
  assign rd_val_o = val_rd_q;

endmodule
